// ===== rtl/sorted_table_first_match_search_top_assert.svh =====
// Assertion macros used by the sorted table search RTL
`ifndef SORTED_TABLE_FIRST_MATCH_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_FIRST_MATCH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define STFMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define STFMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stfms_pkg.sv =====
// Package: sizes, operation codes and beat types of the sorted table search
`timescale 1ns / 1ps

package stfms_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ELEM_W = 32;
    localparam int LEN_W  = 11;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] load_address;
        logic [ELEM_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_index;
    } t_out_item;

endpackage

// ===== rtl/sorted_table_first_match_search_top.sv =====
// Top level: first-occurrence binary search over a loadable sorted table
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): a load beat
// writes item_value at load_address and gives no result; a search beat
// looks for item_value among the first table_length entries.
// Output channel (o_out_valid / i_out_stall, payload o_out_item): one beat
// per search with found and the first matching index (0 when not found).
// Config: i_cfg_wr_en writes table_length from i_cfg_wr_data; write it
// only while no search is in flight. Lengths above 1024 act as 1024.
// A load does not stall the input. A search raises its result after B
// bisection probes (at most 11, none for an empty table, one table read
// per cycle) and L walk reads, one per equal entry stepped over plus one
// for the unequal entry that stops the walk (none when the walk ends at
// index 0). One search is in flight at a time; the single table read port
// sets the pace. The input stalls while a search runs.
// A finished result sits in an output register, so the next beat is taken
// while it waits; a second result waits in the final state until the
// receiver drops stall.
// Reset (i_rst_n low, synchronous) clears table_length, the state and the
// output valid. Table contents are not cleared; load before searching.
`timescale 1ns / 1ps

module sorted_table_first_match_search_top
    import stfms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

`include "sorted_table_first_match_search_top_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_BIS,
        S_WALK,
        S_EMIT
    } t_state;

    t_state            r_state,     n_state;
    logic [LEN_W-1:0]  r_len,       n_len;
    logic [LEN_W-1:0]  r_lo,        n_lo;
    logic [LEN_W-1:0]  r_hi,        n_hi;
    logic [ADDR_W-1:0] r_mid,       n_mid;
    logic [ADDR_W-1:0] r_idx,       n_idx;
    logic              r_found,     n_found;
    logic [ELEM_W-1:0] r_key,       n_key;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item,  n_out_item;

    logic              in_acc;
    logic [LEN_W-1:0]  len_eff;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ELEM_W-1:0] rd_data;
    logic              cmp_eq;
    logic              cmp_lt;
    logic [LEN_W-1:0]  b_lo;
    logic [LEN_W-1:0]  b_hi;
    logic [LEN_W-1:0]  b_mid;
    logic [LEN_W-1:0]  i_mid;
    logic              st_bis;
    logic              mid_ok;
    logic              srch_acc;
    logic              hit_out;

    stfms_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_item.load_address),
        .i_wr_data (i_in_item.item_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign wr_en       = in_acc && (i_in_item.operation == OP_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign len_eff = (r_len > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : r_len;
    assign i_mid   = (len_eff - LEN_W'(1)) >> 1;

    // Narrow the range from the probe just read and form the next midpoint
    assign cmp_eq = (rd_data == r_key);
    assign cmp_lt = (rd_data < r_key);
    assign b_lo   = cmp_lt ? (LEN_W'(r_mid) + LEN_W'(1)) : r_lo;
    assign b_hi   = cmp_lt ? r_hi : LEN_W'(r_mid);
    assign b_mid  = b_lo + ((b_hi - b_lo - LEN_W'(1)) >> 1);

    assign st_bis   = (r_state == S_BIS);
    assign mid_ok   = (LEN_W'(r_mid) >= r_lo) && (LEN_W'(r_mid) < r_hi);
    assign srch_acc = in_acc && (i_in_item.operation == OP_SEARCH);
    assign hit_out  = (r_state == S_EMIT) && r_found;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_found     = r_found;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        rd_en       = 1'b0;
        rd_addr     = r_mid;

        if (i_cfg_wr_en) begin
            n_len = i_cfg_wr_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_item.operation == OP_SEARCH)) begin
                    n_key = i_in_item.item_value;
                    if (len_eff == '0) begin
                        n_found = 1'b0;
                        n_idx   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_lo    = '0;
                        n_hi    = len_eff;
                        n_mid   = i_mid[ADDR_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = i_mid[ADDR_W-1:0];
                        n_state = S_BIS;
                    end
                end
            end
            S_BIS: begin
                if (cmp_eq) begin
                    n_idx = r_mid;
                    if (r_mid == '0) begin
                        n_found = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_mid - ADDR_W'(1);
                        n_state = S_WALK;
                    end
                end else if (b_lo >= b_hi) begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_lo    = b_lo;
                    n_hi    = b_hi;
                    n_mid   = b_mid[ADDR_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = b_mid[ADDR_W-1:0];
                end
            end
            S_WALK: begin
                // Step left over equal entries
                if (cmp_eq) begin
                    n_idx = r_idx - ADDR_W'(1);
                    if (r_idx == ADDR_W'(1)) begin
                        n_found = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - ADDR_W'(2);
                    end
                end else begin
                    n_found = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_item.found       = r_found;
                    n_out_item.match_index = r_idx;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_key      <= n_key;
        r_out_item <= n_out_item;
    end

    `STFMS_ASSERT_NOW(a_bis_range, i_clk, i_rst_n, st_bis, r_lo < r_hi, "empty probe range")
    `STFMS_ASSERT_NOW(a_bis_mid, i_clk, i_rst_n, st_bis, mid_ok, "probe outside range")
    `STFMS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, srch_acc, r_state != S_IDLE, "no search")
    `STFMS_ASSERT_NOW(a_hit_in_len, i_clk, i_rst_n, hit_out, LEN_W'(r_idx) < len_eff, "bad index")

endmodule

// ===== rtl/stfms_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port
`timescale 1ns / 1ps

module stfms_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== test/tb.sv =====
// Testbench: directed and random checks of the first-match table search
`timescale 1ns / 1ps

module tb;
    import stfms_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 20;
    localparam int ITEM_TARGET = 1100;
    localparam int LONG_PHASE  = 5;
    localparam logic [ELEM_W-1:0] TOP = '1;

    typedef bit [ELEM_W-1:0] t_table [DEPTH];
    typedef bit t_mask [DEPTH];

    typedef struct {
        t_out_item         res;
        logic [ELEM_W-1:0] key;
    } t_answer;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    t_in_item         in_item     = '0;
    logic             out_stall   = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_item;

    // Table as the block holds it, updated on accepted beats
    t_table  model_table;
    t_mask   model_loaded;
    int      model_len = 0;

    // Table as the stimulus planner sees it, ahead of acceptance
    t_table  plan_table;
    t_mask   plan_fresh;
    t_table  plan_ideal;
    int      plan_len = 0;

    t_in_item pending_beats[$];
    t_answer  expected_results[$];

    int idle_pct      = 34;
    int holdoff_left  = 0;
    bit holdoff_done  = 1'b0;
    int quiet_cycles  = 0;
    int n_errors      = 0;
    int n_planned     = 0;
    int n_loads       = 0;
    int n_searches    = 0;
    int n_found       = 0;
    int n_phases      = 0;

    sorted_table_first_match_search_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Bisect the first len entries, then walk left over equal entries.
    // unread returns the first probed entry whose mask bit is clear, or -1.
    function automatic void find_first(input t_table tbl, input t_mask ok, input int len,
                                       input logic [ELEM_W-1:0] key,
                                       output t_out_item res, output int unread);
        int left;
        int right;
        int mid;
        int hit;
        bit walking;
        unread = -1;
        hit    = -1;
        left   = 0;
        right  = (len > DEPTH ? DEPTH : len) - 1;
        while (left <= right && hit < 0) begin
            mid = left + (right - left) / 2;
            if (!ok[mid] && unread < 0) unread = mid;
            if (tbl[mid] == key) begin
                hit = mid;
            end else if (tbl[mid] < key) begin
                left = mid + 1;
            end else begin
                right = mid - 1;
            end
        end
        walking = (hit > 0);
        while (walking) begin
            if (!ok[hit-1] && unread < 0) unread = hit - 1;
            if (tbl[hit-1] == key) begin
                hit--;
                walking = (hit > 0);
            end else begin
                walking = 1'b0;
            end
        end
        res.found       = (hit >= 0);
        res.match_index = (hit >= 0) ? hit[ADDR_W-1:0] : '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [ELEM_W-1:0] key,
                                   input int got, input int want);
        $display("MISMATCH %s (key %h): got %0d, want %0d", what, key, got, want);
        n_errors++;
    endtask

    function automatic void plan_load(input int addr, input logic [ELEM_W-1:0] val);
        t_in_item b;
        b.operation    = OP_LOAD;
        b.load_address = addr[ADDR_W-1:0];
        b.item_value   = val;
        pending_beats.push_back(b);
        plan_table[addr] = val;
        plan_fresh[addr] = 1'b1;
        n_planned++;
    endfunction

    // Load every entry the search would probe that this phase has not written
    function automatic void plan_search(input logic [ELEM_W-1:0] key);
        t_in_item  b;
        t_out_item r;
        int        unread;
        find_first(plan_table, plan_fresh, plan_len, key, r, unread);
        while (unread >= 0) begin
            plan_load(unread, plan_ideal[unread]);
            find_first(plan_table, plan_fresh, plan_len, key, r, unread);
        end
        b.operation    = OP_SEARCH;
        b.load_address = ADDR_W'($urandom_range(0, DEPTH - 1));
        b.item_value   = key;
        pending_beats.push_back(b);
        n_planned++;
    endfunction

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic start_phase(input int len, input int pct);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[LEN_W-1:0];
        model_len = len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        plan_len = (len > DEPTH) ? DEPTH : len;
        foreach (plan_fresh[i]) plan_fresh[i] = 1'b0;
        idle_pct = pct;
        n_phases++;
    endtask

    // Input driver: predict on each accepted beat, then offer the next one
    always @(posedge clk) begin : drive_in
        t_answer ans;
        int      unread;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (in_item.operation == OP_LOAD) begin
                    model_table[in_item.load_address]  = in_item.item_value;
                    model_loaded[in_item.load_address] = 1'b1;
                    n_loads++;
                end else begin
                    find_first(model_table, model_loaded, model_len, in_item.item_value,
                               ans.res, unread);
                    ans.key = in_item.item_value;
                    expected_results.push_back(ans);
                    n_searches++;
                end
            end
            if (!in_valid || !in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_item  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each beat with the oldest expected answer
    always @(posedge clk) begin : watch_out
        t_answer ans;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no search pending", '0,
                                    int'(out_item.match_index), 0);
                end else begin
                    ans = expected_results.pop_front();
                    if (out_item.found !== ans.res.found)
                        report_mismatch("found", ans.key, int'(out_item.found),
                                        int'(ans.res.found));
                    if (out_item.match_index !== ans.res.match_index)
                        report_mismatch("match_index", ans.key, int'(out_item.match_index),
                                        int'(ans.res.match_index));
                    if (ans.res.found) n_found++;
                end
            end
            // Hold off once for a long stretch while the sender keeps offering
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                out_stall    <= 1'b1;
            end else if (!holdoff_done && pending_beats.size() >= 30) begin
                holdoff_left <= HOLD_CYCLES;
                holdoff_done <= 1'b1;
                out_stall    <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        longint             v;
        int                 len;
        int                 pct;
        int                 mode;
        int                 run;
        int                 n_srch;
        int                 idx;
        int                 phase_no;
        bit                 unsorted;
        logic [ELEM_W-1:0]  key;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: nothing is read, nothing is found
        start_phase(0, 34);
        plan_load(DEPTH - 1, TOP);
        plan_search('0);
        plan_search(TOP);

        // Extremes of the element range and a run of duplicates
        start_phase(5, 34);
        plan_load(0, '0);
        plan_load(1, 32'd5);
        plan_load(2, 32'd5);
        plan_load(3, 32'd5);
        plan_load(4, TOP);
        plan_search('0);
        plan_search(32'd5);
        plan_search(TOP);
        plan_search(32'd3);
        plan_search(32'd6);
        plan_search(32'h8000_0000);

        // All equal, then broken order
        start_phase(3, 34);
        plan_load(0, 32'd9);
        plan_load(1, 32'd9);
        plan_load(2, 32'd9);
        plan_search(32'd9);
        plan_search(32'd10);
        plan_load(1, 32'd1);
        plan_search(32'd9);

        // Single entry
        start_phase(1, 34);
        plan_load(0, 32'd9);
        plan_search(32'd9);
        plan_search(32'd8);

        phase_no = 0;
        while (n_planned < ITEM_TARGET) begin
            case (phase_no % 8)
                0:       len = DEPTH;
                3:       len = (phase_no == 3) ? 2047 : $urandom_range(DEPTH + 1, 2047);
                6:       len = $urandom_range(0, 1);
                default: len = $urandom_range(2, 48);
            endcase
            pct = (phase_no >= 8 && phase_no < 12) ? 0 : 34;
            start_phase(len, pct);

            // Ascending contents with duplicate runs; loaded lazily as probed
            mode = $urandom_range(0, 2);
            v    = (mode == 2) ? longint'($urandom) : longint'($urandom_range(0, 1000));
            run  = 0;
            for (int i = 0; i < plan_len; i++) begin
                plan_ideal[i] = v[ELEM_W-1:0];
                if (run > 0) begin
                    run--;
                end else if ($urandom_range(0, 15) == 0) begin
                    run = $urandom_range(1, 48);
                end else begin
                    case (mode)
                        0:       v += $urandom_range(0, 3);
                        1:       v += $urandom_range(1, 1 << 16);
                        default: v += $urandom_range(0, 1 << 26);
                    endcase
                end
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            end

            unsorted = ($urandom_range(0, 4) == 0);
            n_srch   = (phase_no == LONG_PHASE) ? 80 : $urandom_range(8, 30);
            for (int s = 0; s < n_srch && n_planned < ITEM_TARGET; s++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if (unsorted && plan_len > 0)
                        plan_load($urandom_range(0, plan_len - 1), $urandom);
                    else if (plan_len < DEPTH)
                        plan_load($urandom_range(plan_len, DEPTH - 1), $urandom);
                end
                idx = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: key = plan_ideal[idx];
                    6:       key = $urandom_range(0, 1) ? plan_ideal[idx] + 32'd1
                                                        : plan_ideal[idx] - 32'd1;
                    7:       key = plan_table[idx];
                    8:       key = $urandom_range(0, 1) ? TOP : '0;
                    default: key = $urandom;
                endcase
                plan_search(key);
            end
            phase_no++;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("searches left without a result", '0, 0,
                            expected_results.size());
        $display("covered %0d loads and %0d searches (%0d hits) over %0d table lengths",
                 n_loads, n_searches, n_found, n_phases);
        if (n_errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sorted_table_first_match_search_top.f =====
+incdir+rtl
rtl/stfms_pkg.sv
rtl/stfms_ram.sv
rtl/sorted_table_first_match_search_top.sv
test/tb.sv
